### src/cau_pkg.sv
// cau_pkg: shared types and constants for the complex arithmetic unit.
// Word layouts, opcode and status codes, pipeline control struct.
// No dependencies.
package cau_pkg;

  localparam int DataWidth   = 32;
  localparam int FracBitsDef = 16;
  localparam int ProdWidth   = 2 * DataWidth;
  localparam int SumWidth    = 2 * DataWidth + 1;

  typedef enum logic [2:0] {
    OpAdd  = 3'd0,
    OpSub  = 3'd1,
    OpMul  = 3'd2,
    OpDiv  = 3'd3,
    OpConj = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StSat     = 2'd1,
    StDivZero = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]                  mode;
    logic signed [DataWidth-1:0] acc_re;
    logic signed [DataWidth-1:0] acc_im;
    logic signed [DataWidth-1:0] amt_re;
    logic signed [DataWidth-1:0] amt_im;
  } in_word_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] res_re;
    logic signed [DataWidth-1:0] res_im;
    logic [1:0]                  status;
  } out_word_t;

  typedef struct packed {
    logic valid;
    logic is_div;
    logic div_zero;
    logic neg_re;
    logic neg_im;
  } ctl_t;

endpackage

### src/cau_front.sv
// cau_front: operand register, products, sums and divide preparation.
// Four register stages. Depends on cau_pkg.
module cau_front #(
  parameter int FRAC_BITS = cau_pkg::FracBitsDef
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic                                   in_valid_i,
  input  cau_pkg::in_word_t                      in_word_i,
  output cau_pkg::ctl_t                          ctl_o,
  output logic [cau_pkg::SumWidth+FRAC_BITS:0]   val_re_o,
  output logic [cau_pkg::SumWidth+FRAC_BITS:0]   val_im_o,
  output logic [cau_pkg::SumWidth-1:0]           den_o
);

  localparam int W  = cau_pkg::DataWidth;
  localparam int PW = cau_pkg::ProdWidth;
  localparam int SW = cau_pkg::SumWidth;
  localparam int VW = SW + FRAC_BITS + 1;

  // stage A: operands
  logic                 valid_a_q;
  cau_pkg::in_word_t    in_a_q;

  // stage B: products and simple results
  logic                 valid_b_q;
  logic [2:0]           mode_b_q;
  logic signed [PW-1:0] ac_q, bd_q, bc_q, ad_q, cc_q, dd_q;
  logic signed [W:0]    sre_b_q, sim_b_q;
  logic signed [W:0]    sre_b_d, sim_b_d;

  // stage C: sums
  logic                 valid_c_q;
  logic [2:0]           mode_c_q;
  logic signed [SW-1:0] sum_re_q, sum_im_q, sum_re_d, sum_im_d;
  logic [SW-1:0]        den_c_q;
  logic signed [W:0]    sre_c_q, sim_c_q;

  // stage D: rescaled values or divide numerators
  logic                 valid_d_q;
  cau_pkg::ctl_t        ctl_d_q, ctl_d_d;
  logic [VW-1:0]        val_re_q, val_im_q, val_re_d, val_im_d;
  logic [SW-1:0]        den_d_q;
  logic signed [SW-1:0] shr_re, shr_im;
  logic [SW-1:0]        mag_re, mag_im;

  always_comb begin
    case (in_a_q.mode)
      cau_pkg::OpAdd: begin
        sre_b_d = (W+1)'(in_a_q.acc_re) + (W+1)'(in_a_q.amt_re);
        sim_b_d = (W+1)'(in_a_q.acc_im) + (W+1)'(in_a_q.amt_im);
      end
      cau_pkg::OpSub: begin
        sre_b_d = (W+1)'(in_a_q.acc_re) - (W+1)'(in_a_q.amt_re);
        sim_b_d = (W+1)'(in_a_q.acc_im) - (W+1)'(in_a_q.amt_im);
      end
      cau_pkg::OpConj: begin
        sre_b_d = (W+1)'(in_a_q.amt_re);
        sim_b_d = -(W+1)'(in_a_q.amt_im);
      end
      default: begin
        sre_b_d = (W+1)'(in_a_q.acc_re);
        sim_b_d = (W+1)'(in_a_q.acc_im);
      end
    endcase
  end

  always_comb begin
    if (mode_b_q == cau_pkg::OpDiv) begin
      sum_re_d = SW'(ac_q) + SW'(bd_q);
      sum_im_d = SW'(bc_q) - SW'(ad_q);
    end else begin
      sum_re_d = SW'(ac_q) - SW'(bd_q);
      sum_im_d = SW'(bc_q) + SW'(ad_q);
    end
  end

  assign shr_re = sum_re_q >>> FRAC_BITS;
  assign shr_im = sum_im_q >>> FRAC_BITS;
  // negating the most negative sum still gives the right unsigned magnitude
  assign mag_re = sum_re_q[SW-1] ? SW'(-sum_re_q) : SW'(sum_re_q);
  assign mag_im = sum_im_q[SW-1] ? SW'(-sum_im_q) : SW'(sum_im_q);

  always_comb begin
    ctl_d_d.valid    = valid_c_q;
    ctl_d_d.is_div   = (mode_c_q == cau_pkg::OpDiv);
    ctl_d_d.div_zero = (den_c_q == '0);
    ctl_d_d.neg_re   = sum_re_q[SW-1];
    ctl_d_d.neg_im   = sum_im_q[SW-1];
    case (mode_c_q)
      cau_pkg::OpMul: begin
        val_re_d = {{(VW-SW){shr_re[SW-1]}}, shr_re};
        val_im_d = {{(VW-SW){shr_im[SW-1]}}, shr_im};
      end
      cau_pkg::OpDiv: begin
        val_re_d = {1'b0, mag_re, {FRAC_BITS{1'b0}}};
        val_im_d = {1'b0, mag_im, {FRAC_BITS{1'b0}}};
      end
      default: begin
        val_re_d = {{(VW-W-1){sre_c_q[W]}}, sre_c_q};
        val_im_d = {{(VW-W-1){sim_c_q[W]}}, sim_c_q};
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      valid_c_q <= 1'b0;
      valid_d_q <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= in_valid_i;
      valid_b_q <= valid_a_q;
      valid_c_q <= valid_b_q;
      valid_d_q <= ctl_d_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      in_a_q   <= in_word_i;
      mode_b_q <= in_a_q.mode;
      ac_q     <= PW'(in_a_q.acc_re) * PW'(in_a_q.amt_re);
      bd_q     <= PW'(in_a_q.acc_im) * PW'(in_a_q.amt_im);
      bc_q     <= PW'(in_a_q.acc_im) * PW'(in_a_q.amt_re);
      ad_q     <= PW'(in_a_q.acc_re) * PW'(in_a_q.amt_im);
      cc_q     <= PW'(in_a_q.amt_re) * PW'(in_a_q.amt_re);
      dd_q     <= PW'(in_a_q.amt_im) * PW'(in_a_q.amt_im);
      sre_b_q  <= sre_b_d;
      sim_b_q  <= sim_b_d;
      mode_c_q <= mode_b_q;
      sum_re_q <= sum_re_d;
      sum_im_q <= sum_im_d;
      den_c_q  <= SW'(cc_q) + SW'(dd_q);
      sre_c_q  <= sre_b_q;
      sim_c_q  <= sim_b_q;
      ctl_d_q  <= ctl_d_d;
      val_re_q <= val_re_d;
      val_im_q <= val_im_d;
      den_d_q  <= den_c_q;
    end
  end

  assign ctl_o    = {valid_d_q, ctl_d_q.is_div, ctl_d_q.div_zero, ctl_d_q.neg_re,
                     ctl_d_q.neg_im};
  assign val_re_o = val_re_q;
  assign val_im_o = val_im_q;
  assign den_o    = den_d_q;

endmodule

### src/cau_div_stage.sv
// cau_div_stage: one restoring division step for both parts of a word.
// Develops one quotient bit per part; other words pass unchanged.
// Depends on cau_pkg.
module cau_div_stage #(
  parameter int FRAC_BITS = cau_pkg::FracBitsDef
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  cau_pkg::ctl_t                          ctl_i,
  input  logic [cau_pkg::SumWidth-1:0]           den_i,
  input  logic [cau_pkg::SumWidth-1:0]           rem_re_i,
  input  logic [cau_pkg::SumWidth-1:0]           rem_im_i,
  input  logic [cau_pkg::SumWidth+FRAC_BITS:0]   num_re_i,
  input  logic [cau_pkg::SumWidth+FRAC_BITS:0]   num_im_i,
  output cau_pkg::ctl_t                          ctl_o,
  output logic [cau_pkg::SumWidth-1:0]           den_o,
  output logic [cau_pkg::SumWidth-1:0]           rem_re_o,
  output logic [cau_pkg::SumWidth-1:0]           rem_im_o,
  output logic [cau_pkg::SumWidth+FRAC_BITS:0]   num_re_o,
  output logic [cau_pkg::SumWidth+FRAC_BITS:0]   num_im_o
);

  localparam int RW = cau_pkg::SumWidth;
  localparam int MW = RW + FRAC_BITS;

  logic           valid_q;
  cau_pkg::ctl_t  ctl_q;
  logic [RW-1:0]  den_q, rem_re_q, rem_im_q, rem_re_d, rem_im_d, t_re, t_im;
  logic [MW:0]    num_re_q, num_im_q, num_re_d, num_im_d;
  logic           ge_re, ge_im;

  // numerator bits leave at the top, quotient bits enter at the bottom
  assign t_re  = {rem_re_i[RW-2:0], num_re_i[MW-1]};
  assign t_im  = {rem_im_i[RW-2:0], num_im_i[MW-1]};
  assign ge_re = (t_re >= den_i);
  assign ge_im = (t_im >= den_i);

  always_comb begin
    if (ctl_i.is_div) begin
      rem_re_d = ge_re ? t_re - den_i : t_re;
      rem_im_d = ge_im ? t_im - den_i : t_im;
      num_re_d = {1'b0, num_re_i[MW-2:0], ge_re};
      num_im_d = {1'b0, num_im_i[MW-2:0], ge_im};
    end else begin
      rem_re_d = rem_re_i;
      rem_im_d = rem_im_i;
      num_re_d = num_re_i;
      num_im_d = num_im_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q    <= ctl_i;
      den_q    <= den_i;
      rem_re_q <= rem_re_d;
      rem_im_q <= rem_im_d;
      num_re_q <= num_re_d;
      num_im_q <= num_im_d;
    end
  end

  assign ctl_o    = {valid_q, ctl_q.is_div, ctl_q.div_zero, ctl_q.neg_re, ctl_q.neg_im};
  assign den_o    = den_q;
  assign rem_re_o = rem_re_q;
  assign rem_im_o = rem_im_q;
  assign num_re_o = num_re_q;
  assign num_im_o = num_im_q;

endmodule

### src/cau_sat.sv
// cau_sat: quotient sign fix-up, saturation, status and output register.
// Depends on cau_pkg.
module cau_sat #(
  parameter int FRAC_BITS = cau_pkg::FracBitsDef
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  cau_pkg::ctl_t                          ctl_i,
  input  logic [cau_pkg::SumWidth+FRAC_BITS:0]   val_re_i,
  input  logic [cau_pkg::SumWidth+FRAC_BITS:0]   val_im_i,
  output logic                                   out_valid_o,
  output cau_pkg::out_word_t                     out_word_o
);

  localparam int W  = cau_pkg::DataWidth;
  localparam int VW = cau_pkg::SumWidth + FRAC_BITS + 1;

  logic [VW-1:0]       fix_re, fix_im;
  logic                ovf_re, ovf_im;
  logic [W-1:0]        res_re, res_im;
  logic                valid_q;
  cau_pkg::out_word_t  word_q, word_d;

  assign fix_re = (ctl_i.is_div && ctl_i.neg_re) ? VW'(-val_re_i) : val_re_i;
  assign fix_im = (ctl_i.is_div && ctl_i.neg_im) ? VW'(-val_im_i) : val_im_i;

  // fits when every bit above the result's sign copies it
  assign ovf_re = !((&fix_re[VW-1:W-1]) || !(|fix_re[VW-1:W-1]));
  assign ovf_im = !((&fix_im[VW-1:W-1]) || !(|fix_im[VW-1:W-1]));

  assign res_re = ovf_re ? {fix_re[VW-1], {(W-1){!fix_re[VW-1]}}} : fix_re[W-1:0];
  assign res_im = ovf_im ? {fix_im[VW-1], {(W-1){!fix_im[VW-1]}}} : fix_im[W-1:0];

  always_comb begin
    if (ctl_i.is_div && ctl_i.div_zero) begin
      word_d.res_re = '0;
      word_d.res_im = '0;
      word_d.status = cau_pkg::StDivZero;
    end else begin
      word_d.res_re = res_re;
      word_d.res_im = res_im;
      word_d.status = (ovf_re || ovf_im) ? cau_pkg::StSat : cau_pkg::StOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

### src/complex_arith_unit.sv
// complex_arith_unit: pipelined complex ALU, signed Q16.16 by default.
// Stages: four front stages, one divider stage per quotient bit, one output
// register. Every op takes the same path.
// Throughput: one word per cycle while no output word waits unread.
// The whole pipeline holds while the output word waits unread.
// Reset clears the valid bits only; no clearing pass.
module complex_arith_unit #(
  parameter int FRAC_BITS = cau_pkg::FracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cau_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cau_pkg::out_word_t  out_word_o
);

  localparam int RW = cau_pkg::SumWidth;
  localparam int MW = RW + FRAC_BITS;

  logic           en;
  cau_pkg::ctl_t  ctl [MW+1];
  logic [RW-1:0]  den [MW+1];
  logic [RW-1:0]  rem_re [MW+1];
  logic [RW-1:0]  rem_im [MW+1];
  logic [MW:0]    num_re [MW+1];
  logic [MW:0]    num_im [MW+1];

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (in_valid_i),
    .in_word_i  (in_word_i),
    .ctl_o      (ctl[0]),
    .val_re_o   (num_re[0]),
    .val_im_o   (num_im[0]),
    .den_o      (den[0])
  );

  assign rem_re[0] = '0;
  assign rem_im[0] = '0;

  for (genvar i = 0; i < MW; i++) begin : g_div
    cau_div_stage #(.FRAC_BITS(FRAC_BITS)) u_stage (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .ctl_i    (ctl[i]),
      .den_i    (den[i]),
      .rem_re_i (rem_re[i]),
      .rem_im_i (rem_im[i]),
      .num_re_i (num_re[i]),
      .num_im_i (num_im[i]),
      .ctl_o    (ctl[i+1]),
      .den_o    (den[i+1]),
      .rem_re_o (rem_re[i+1]),
      .rem_im_o (rem_im[i+1]),
      .num_re_o (num_re[i+1]),
      .num_im_o (num_im[i+1])
    );
  end

  cau_sat #(.FRAC_BITS(FRAC_BITS)) u_sat (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .ctl_i       (ctl[MW]),
    .val_re_i    (num_re[MW]),
    .val_im_i    (num_im[MW]),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule

### tb/sv/complex_arith_unit_test.sv
// complex_arith_unit_test: self-checking bench for the complex ALU.
// Predicts each result word in-bench and compares it with the DUT output stream.
// Depends on cau_pkg and complex_arith_unit.
`timescale 1ns / 1ps

module complex_arith_unit_test;

  localparam int FracBits = cau_pkg::FracBitsDef;
  localparam longint MaxV = 64'sd2147483647;
  localparam longint MinV = -64'sd2147483648;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  cau_pkg::in_word_t  in_word_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  cau_pkg::out_word_t out_word_o;

  cau_pkg::out_word_t expected_words[$];
  int                 mismatches = 0;
  bit                 calm = 1'b0;  // no idling on either side while set

  complex_arith_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_word_i(in_word_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_word_o(out_word_o)
  );

  always #2 clk_i = ~clk_i;

  // clamp to 32-bit signed range; flag set on clamp
  function automatic logic signed [31:0] clamp32(input logic signed [129:0] v,
                                                 inout bit hit);
    if (v > MaxV) begin
      hit = 1'b1;
      return MaxV[31:0];
    end
    if (v < MinV) begin
      hit = 1'b1;
      return MinV[31:0];
    end
    return v[31:0];
  endfunction

  // truncating signed division of (num << FracBits) by den
  function automatic logic signed [129:0] frac_quot(input logic signed [129:0] num,
                                                    input logic signed [129:0] den);
    logic signed [129:0] mag;
    logic signed [129:0] q;
    mag = (num < 0) ? -num : num;
    q = (mag <<< FracBits) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic cau_pkg::out_word_t complex_result(input cau_pkg::in_word_t w);
    logic signed [129:0] a, b, c, d, re, im, den;
    bit hit;
    cau_pkg::out_word_t r;
    hit = 1'b0;
    a = w.acc_re; b = w.acc_im; c = w.amt_re; d = w.amt_im;
    re = a; im = b;
    case (w.mode)
      cau_pkg::OpAdd: begin re = a + c; im = b + d; end
      cau_pkg::OpSub: begin re = a - c; im = b - d; end
      cau_pkg::OpMul: begin
        re = (a * c - b * d) >>> FracBits;
        im = (b * c + a * d) >>> FracBits;
      end
      cau_pkg::OpDiv: begin
        den = c * c + d * d;
        if (den == 0) begin
          r.res_re = '0; r.res_im = '0; r.status = cau_pkg::StDivZero;
          return r;
        end
        re = frac_quot(a * c + b * d, den);
        im = frac_quot(b * c - a * d, den);
      end
      cau_pkg::OpConj: begin re = c; im = -d; end
      default: ;
    endcase
    r.res_re = clamp32(re, hit);
    r.res_im = clamp32(im, hit);
    r.status = hit ? cau_pkg::StSat : cau_pkg::StOk;
    return r;
  endfunction

  function automatic logic [31:0] pick_part();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3, 4: return $urandom_range(0, 65535) << 8;
      5, 6: return -($urandom_range(0, 65535) << 8);
      7: return $urandom_range(0, 2047) - 1024;
      default: return $urandom;
    endcase
  endfunction

  // called just after a rising edge; returns at the accepting edge with valid
  // still high, so the next word can follow with no gap
  task automatic send_word(input logic [2:0] m, input logic [31:0] ar, ai, br, bi);
    cau_pkg::in_word_t w;
    w.mode = m; w.acc_re = ar; w.acc_im = ai; w.amt_re = br; w.amt_im = bi;
    while (!calm && $urandom_range(0, 99) < 33) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    expected_words.push_back(complex_result(w));
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_random();
    send_word($urandom_range(0, 99) < 8 ? 3'($urandom_range(5, 7))
                                        : 3'($urandom_range(0, 4)),
              pick_part(), pick_part(), pick_part(), pick_part());
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_extremes();
    logic [31:0] ex[4];
    ex = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
    for (int m = 0; m < 5; m++) begin
      send_word(m[2:0], ex[m % 4], ex[(m + 1) % 4], ex[(m + 2) % 4], ex[(m + 3) % 4]);
    end
    send_word(cau_pkg::OpConj, 0, 0, 32'h8000_0000, 32'h8000_0000);
    send_word(cau_pkg::OpDiv, 32'h0001_0000, 32'h0002_0000, 0, 0);
    send_word(cau_pkg::OpDiv, 32'h7fff_ffff, 32'h8000_0000, 1, 0);
    send_word(cau_pkg::OpDiv, 32'h0003_0000, 32'hfffe_0000, 32'h0001_0000,
              32'h0001_0000);
    send_word(cau_pkg::OpMul, 32'hffff_ffff, 1, 32'hffff_ffff, 32'h8000_0000);
    send_word(cau_pkg::OpMul, 32'h0002_8000, 32'hffff_0000, 32'h0001_8000,
              32'h0000_4000);
    send_word(cau_pkg::OpAdd, 32'h7fff_ffff, 32'h8000_0000, 1, 32'hffff_ffff);
    send_word(cau_pkg::OpSub, 32'h8000_0000, 32'h7fff_ffff, 1, 32'hffff_ffff);
    send_word(3'd5, 32'h1234_5678, 32'h8765_4321, 0, 0);
    send_word(3'd6, 32'hffff_ffff, 0, 1, 1);
    send_word(3'd7, 32'h5555_aaaa, 32'haaaa_5555, 2, 3);
  endtask

  task automatic test_random();
    for (int i = 0; i < 200; i++) send_random();
    drain();  // sender holds off until every word is back
    calm = 1'b1;
    for (int i = 0; i < 60; i++) send_random();
    calm = 1'b0;
    for (int i = 0; i < 170; i++) send_random();
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %h", out_word_o);
        end else begin
          cau_pkg::out_word_t e;
          e = expected_words.pop_front();
          if (out_word_o.res_re !== e.res_re || out_word_o.res_im !== e.res_im ||
              out_word_o.status !== e.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp re %h im %h st %0d, got re %h im %h st %0d",
                       e.res_re, e.res_im, e.status,
                       out_word_o.res_re, out_word_o.res_im, out_word_o.status);
          end
        end
      end
      out_ready_i <= calm || ($urandom_range(0, 99) >= 33);
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_random();
    drain();
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && expected_words.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
